// File: rtl/fixed_point_line_rasterizer_unit_assert.svh
// Assertion macros used by the line rasterizer top level.
`ifndef FIXED_POINT_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define FIXED_POINT_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LRZ_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line rasterizer check failed");

// Next-cycle implication.
`define LRZ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line rasterizer check failed");

`endif

// File: rtl/lrz_pkg.sv
// Types and constants shared by the line rasterizer modules.
package lrz_pkg;

   localparam int COORD_BITS_DEF = 9;
   localparam int FRAC_BITS_DEF  = 12;
   localparam int COLOR_BITS     = 16;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      KIND_VERT = 2'd0,
      KIND_HORZ = 2'd1,
      KIND_XMAJ = 2'd2,
      KIND_YMAJ = 2'd3
   } kind_type;

   typedef struct packed {
      logic     is_load;
      kind_type kind;
      logic     walk_down;
   } ctl_type;

endpackage

// File: rtl/fixed_point_line_rasterizer_unit.sv
// Line rasterizer top level: front end, command queue and pixel walker.
//
// A load word latches a line and gives no pixel; each following step word gives
// one pixel until the line's end, the last flagged with last_pixel. Step words
// are taken one per cycle and pixels leave one per cycle while the result side
// keeps up. A load holds the input while setup runs: a vertical or horizontal
// line goes from classification straight to the queue push; a sloped line first
// runs the shared restoring divider, which forms slope and then intercept one
// quotient bit per cycle. Either load waits longer if the queue has no room
// when setup ends. A two-word queue separates setup from the walker, so pixels
// of the previous line keep flowing during a load setup.
`include "fixed_point_line_rasterizer_unit_assert.svh"

module fixed_point_line_rasterizer_unit #(
   parameter int COORD_BITS = lrz_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = lrz_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [COORD_BITS-1:0]          req_x_start,
   input  logic [COORD_BITS-1:0]          req_y_start,
   input  logic [COORD_BITS-1:0]          req_x_end,
   input  logic [COORD_BITS-1:0]          req_y_end,
   input  logic [lrz_pkg::COLOR_BITS-1:0] req_line_color,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [COORD_BITS-1:0]          rsp_pixel_x,
   output logic [COORD_BITS-1:0]          rsp_pixel_y,
   output logic [lrz_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                           rsp_last_pixel
);
   import lrz_pkg::*;

   localparam int MW = 2 * COORD_BITS + FRAC_BITS;
   localparam int IW = MW + 1;
   localparam int SW = FRAC_BITS + 2;
   localparam int EW = $bits(ctl_type) + 3 * COORD_BITS + SW + IW + COLOR_BITS;

   logic          q_push, q_pop, q_full, q_valid;
   logic [EW-1:0] q_wdata, q_rdata;

   lrz_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .EW         (EW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_wdata)
   );

   lrz_queue #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .full      (q_full),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   lrz_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .EW         (EW)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_data          (q_rdata),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   `LRZ_ASSERT_IMPLY(a_push_room, clock, reset, q_push, !q_full)
   `LRZ_ASSERT_IMPLY(a_pop_valid, clock, reset, q_pop, q_valid)
   `LRZ_ASSERT_IMPLY(a_step_queued, clock, reset,
      req_valid && req_ready && req_operation == OP_STEP, q_push)
   `LRZ_ASSERT_NEXT(a_load_busy, clock, reset,
      req_valid && req_ready && req_operation == OP_LOAD, !req_ready)

endmodule

// File: rtl/lrz_div.sv
// Restoring divider: unsigned magnitude, one quotient bit per cycle, signed result.
module lrz_div #(
   parameter int NUM_BITS = 30,
   parameter int DEN_BITS = 9
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   input  logic                neg,
   output logic                done,
   output logic [NUM_BITS:0]   quotient
);
   localparam int CW = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic                neg_ff, neg_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                ge;

   assign trial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         neg_in  = neg;
         cnt_in  = CW'(NUM_BITS);
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quo_in  = {quo_ff[NUM_BITS-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         busy_in = cnt_ff != CW'(1);
         done_in = cnt_ff == CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};

endmodule

// File: rtl/lrz_front.sv
// Front end: accepts words, classifies loads and runs the slope/intercept setup.
module lrz_front #(
   parameter int COORD_BITS = 9,
   parameter int FRAC_BITS  = 12,
   parameter int EW         = 100
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [COORD_BITS-1:0]           req_x_start,
   input  logic [COORD_BITS-1:0]           req_y_start,
   input  logic [COORD_BITS-1:0]           req_x_end,
   input  logic [COORD_BITS-1:0]           req_y_end,
   input  logic [lrz_pkg::COLOR_BITS-1:0]  req_line_color,
   input  logic                            q_full,
   output logic                            q_push,
   output logic [EW-1:0]                   q_data
);
   import lrz_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int MW = 2 * COORD_BITS + FRAC_BITS;
   localparam int IW = MW + 1;
   localparam int SW = FRAC_BITS + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CLASS,
      S_SLOPE,
      S_ICPT,
      S_PUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [C-1:0]          x0_ff, y0_ff, x1_ff, y1_ff;
   logic [COLOR_BITS-1:0] color_ff;
   kind_type              kind_ff, kind_in;
   logic [C-1:0]          pos_ff, pos_in;
   logic [C-1:0]          end_ff, end_in;
   logic                  down_ff, down_in;
   logic [C-1:0]          fixed_ff, fixed_in;
   logic [SW-1:0]         slope_ff, slope_in;
   logic [IW-1:0]         icpt_ff, icpt_in;
   logic [C-1:0]          span_ff, span_in;
   logic [2*C-1:0]        imag_ff, imag_in;
   logic                  ineg_ff, ineg_in;

   logic                  accept;
   logic [C-1:0]          dx, dy, m0, n0, m1, n1, span, dn_mag;
   logic                  dn_neg, ic_neg;
   logic [2*C-1:0]        p_a, p_b, ic_mag;
   kind_type              cls_kind;
   logic                  div_start, div_neg, div_done;
   logic [MW-1:0]         div_num;
   logic [C-1:0]          div_den;
   logic [IW-1:0]         div_q;
   ctl_type               ctl;

   assign req_ready = (state_ff == S_IDLE) && !q_full;
   assign accept    = req_valid && req_ready;

   // classification of the latched endpoints
   always_comb begin
      dx = (x1_ff > x0_ff) ? x1_ff - x0_ff : x0_ff - x1_ff;
      dy = (y1_ff > y0_ff) ? y1_ff - y0_ff : y0_ff - y1_ff;
      if (x0_ff == x1_ff)
         cls_kind = KIND_VERT;
      else if (y0_ff == y1_ff)
         cls_kind = KIND_HORZ;
      else if (dx > dy)
         cls_kind = KIND_XMAJ;
      else
         cls_kind = KIND_YMAJ;
      if (cls_kind == KIND_XMAJ) begin
         if (x0_ff > x1_ff) begin
            m0 = x1_ff; n0 = y1_ff; m1 = x0_ff; n1 = y0_ff;
         end else begin
            m0 = x0_ff; n0 = y0_ff; m1 = x1_ff; n1 = y1_ff;
         end
      end else begin
         if (y0_ff > y1_ff) begin
            m0 = y1_ff; n0 = x1_ff; m1 = y0_ff; n1 = x0_ff;
         end else begin
            m0 = y0_ff; n0 = x0_ff; m1 = y1_ff; n1 = x1_ff;
         end
      end
      span   = m1 - m0;
      dn_neg = n1 < n0;
      dn_mag = dn_neg ? n0 - n1 : n1 - n0;
      p_a    = {{C{1'b0}}, n0} * {{C{1'b0}}, m1};
      p_b    = {{C{1'b0}}, n1} * {{C{1'b0}}, m0};
      ic_neg = p_b > p_a;
      ic_mag = ic_neg ? p_b - p_a : p_a - p_b;
   end

   assign div_start = ((state_ff == S_CLASS) && (cls_kind == KIND_XMAJ || cls_kind == KIND_YMAJ))
                      || ((state_ff == S_SLOPE) && div_done);
   assign div_num   = (state_ff == S_CLASS) ? {{C{1'b0}}, dn_mag, {FRAC_BITS{1'b0}}}
                                            : {imag_ff, {FRAC_BITS{1'b0}}};
   assign div_neg   = (state_ff == S_CLASS) ? dn_neg : ineg_ff;
   assign div_den   = (state_ff == S_CLASS) ? span : span_ff;

   lrz_div #(
      .NUM_BITS (MW),
      .DEN_BITS (C)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .neg      (div_neg),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      pos_in   = pos_ff;
      end_in   = end_ff;
      down_in  = down_ff;
      fixed_in = fixed_ff;
      slope_in = slope_ff;
      icpt_in  = icpt_ff;
      span_in  = span_ff;
      imag_in  = imag_ff;
      ineg_in  = ineg_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_operation == OP_LOAD)
               state_in = S_CLASS;
         end
         S_CLASS: begin
            kind_in  = cls_kind;
            slope_in = '0;
            icpt_in  = '0;
            down_in  = 1'b0;
            fixed_in = '0;
            case (cls_kind)
               KIND_VERT: begin
                  fixed_in = x0_ff;
                  pos_in   = y0_ff;
                  end_in   = y1_ff;
                  down_in  = y0_ff > y1_ff;
                  state_in = S_PUSH;
               end
               KIND_HORZ: begin
                  fixed_in = y0_ff;
                  pos_in   = x0_ff;
                  end_in   = x1_ff;
                  down_in  = x0_ff > x1_ff;
                  state_in = S_PUSH;
               end
               default: begin
                  pos_in   = m0;
                  end_in   = m1;
                  span_in  = span;
                  imag_in  = ic_mag;
                  ineg_in  = ic_neg;
                  state_in = S_SLOPE;
               end
            endcase
         end
         S_SLOPE: begin
            if (div_done) begin
               slope_in = div_q[SW-1:0];
               state_in = S_ICPT;
            end
         end
         S_ICPT: begin
            if (div_done) begin
               icpt_in  = div_q;
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!q_full)
               state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept && req_operation == OP_LOAD) begin
         x0_ff    <= req_x_start;
         y0_ff    <= req_y_start;
         x1_ff    <= req_x_end;
         y1_ff    <= req_y_end;
         color_ff <= req_line_color;
      end
      kind_ff  <= kind_in;
      pos_ff   <= pos_in;
      end_ff   <= end_in;
      down_ff  <= down_in;
      fixed_ff <= fixed_in;
      slope_ff <= slope_in;
      icpt_ff  <= icpt_in;
      span_ff  <= span_in;
      imag_ff  <= imag_in;
      ineg_ff  <= ineg_in;
   end

   // step words go straight into the queue; loads after setup
   always_comb begin
      ctl.is_load   = state_ff == S_PUSH;
      ctl.kind      = kind_ff;
      ctl.walk_down = down_ff;
      q_push        = (accept && req_operation == OP_STEP) || (state_ff == S_PUSH && !q_full);
      q_data        = {ctl, pos_ff, end_ff, fixed_ff, slope_ff, icpt_ff, color_ff};
   end

endmodule

// File: rtl/lrz_queue.sv
// Small register FIFO between the front end and the pixel walker.
module lrz_queue #(
   parameter int WIDTH = 100,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full     = cnt_ff == CW'(DEPTH);
   assign valid    = cnt_ff != '0;
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push)
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (pop)
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (push && !pop)
         cnt_in = cnt_ff + CW'(1);
      else if (pop && !push)
         cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push)
         slot_ff[wr_ff] <= push_data;
   end

endmodule

// File: rtl/lrz_back.sv
// Back end: holds the active line and emits one pixel per step word while a line is active.
module lrz_back #(
   parameter int COORD_BITS = 9,
   parameter int FRAC_BITS  = 12,
   parameter int EW         = 100
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  logic [EW-1:0]                  q_data,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [COORD_BITS-1:0]          rsp_pixel_x,
   output logic [COORD_BITS-1:0]          rsp_pixel_y,
   output logic [lrz_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                           rsp_last_pixel
);
   import lrz_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int MW = 2 * COORD_BITS + FRAC_BITS;
   localparam int IW = MW + 1;
   localparam int SW = FRAC_BITS + 2;
   localparam int PW = SW + C + 1;
   localparam int VW = ((IW > PW) ? IW : PW) + 1;

   ctl_type               e_ctl;
   logic [C-1:0]          e_pos, e_end, e_fixed;
   logic [SW-1:0]         e_slope;
   logic [IW-1:0]         e_icpt;
   logic [COLOR_BITS-1:0] e_color;

   logic                  active_ff, active_in;
   kind_type              kind_ff, kind_in;
   logic [C-1:0]          pos_ff, pos_in;
   logic [C-1:0]          end_ff, end_in;
   logic                  down_ff, down_in;
   logic [C-1:0]          fixed_ff, fixed_in;
   logic [SW-1:0]         slope_ff, slope_in;
   logic [IW-1:0]         icpt_ff, icpt_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]          rsp_x_ff, rsp_x_in;
   logic [C-1:0]          rsp_y_ff, rsp_y_in;
   logic [COLOR_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  out_free, emit, last;
   logic signed [PW-1:0]  prod;
   logic signed [VW-1:0]  v;
   logic [C-1:0]          minor, px, py;
   logic                  round_up;

   assign {e_ctl, e_pos, e_end, e_fixed, e_slope, e_icpt, e_color} = q_data;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = q_valid && (e_ctl.is_load || !active_ff || out_free);
   assign emit     = q_pop && !e_ctl.is_load && active_ff;
   assign last     = pos_ff == end_ff;

   // minor = (slope * pos + intercept + half) / one, truncated toward zero
   assign prod     = $signed(slope_ff) * $signed({1'b0, pos_ff});
   assign v        = VW'(prod) + VW'($signed(icpt_ff)) + (VW'(1) <<< (FRAC_BITS - 1));
   assign round_up = v[VW-1] && (v[FRAC_BITS-1:0] != '0);
   assign minor    = v[FRAC_BITS+C-1:FRAC_BITS] + C'(round_up);

   always_comb begin
      case (kind_ff)
         KIND_VERT: begin
            px = fixed_ff;
            py = pos_ff;
         end
         KIND_HORZ: begin
            px = pos_ff;
            py = fixed_ff;
         end
         KIND_XMAJ: begin
            px = pos_ff;
            py = minor;
         end
         default: begin
            px = minor;
            py = pos_ff;
         end
      endcase
   end

   always_comb begin
      active_in    = active_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      down_in      = down_ff;
      fixed_in     = fixed_ff;
      slope_in     = slope_ff;
      icpt_in      = icpt_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;
      if (q_pop && e_ctl.is_load) begin
         active_in = 1'b1;
         kind_in   = e_ctl.kind;
         down_in   = e_ctl.walk_down;
         pos_in    = e_pos;
         end_in    = e_end;
         fixed_in  = e_fixed;
         slope_in  = e_slope;
         icpt_in   = e_icpt;
         color_in  = e_color;
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = px;
         rsp_y_in     = py;
         rsp_color_in = color_ff;
         rsp_last_in  = last;
         if (last)
            active_in = 1'b0;
         else if (down_ff && (kind_ff == KIND_VERT || kind_ff == KIND_HORZ))
            pos_in = pos_ff - C'(1);
         else
            pos_in = pos_ff + C'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      pos_ff       <= pos_in;
      end_ff       <= end_in;
      down_ff      <= down_in;
      fixed_ff     <= fixed_in;
      slope_ff     <= slope_in;
      icpt_ff      <= icpt_in;
      color_ff     <= color_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

endmodule
